[rtl/tcrr_pkg.sv]
// tcrr_pkg: shared types and constants for the tilt compensated range rate block.
// No dependencies.
package tcrr_pkg;

   localparam int AxisW  = 16;
   localparam int RangeW = 24;
   localparam int BoundW = 23;
   localparam int RateW  = 16;
   localparam int TimeW  = 32;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 23;

   localparam logic [CsrIdxW-1:0] CSR_AXIS_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_AXIS_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_AXIS_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_MIN    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_MAX    = 3'd4;

   localparam int TiltLimit = 11583;
   localparam int RateLimit = 20000;
   localparam int UsPerS    = 1000000;

   // divider width: numerator magnitudes up to 2^48
   localparam int DivW = 50;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture input word
      logic [2:0] mstep; // numerator accumulation step
      logic mvalid;
      logic div_start;  // start divider
      logic div_sel;    // 0: range division, 1: rate division
      logic range_take; // latch range quotient
      logic finish;     // update state and output regs
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic tilt_ok;
      logic need_rate;
   } stat_type;

endpackage

[rtl/tcrr_div.sv]
// tcrr_div: radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on tcrr_pkg.
module tcrr_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [tcrr_pkg::DivW-1:0] dividend,
   input  logic [tcrr_pkg::DivW-1:0] divisor,
   output logic [tcrr_pkg::DivW-1:0] quotient,
   output logic done
);
   import tcrr_pkg::*;

   localparam int CntW = $clog2(DivW + 1);

   logic [DivW-1:0] q_ff, q_in;
   logic [DivW:0]   r_ff, r_in;
   logic [DivW-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DivW:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DivW-1:0], q_ff[DivW-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = CntW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivW]) begin
            r_in = trial;
            q_in = {q_ff[DivW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DivW-1:0], q_ff[DivW-1]};
            q_in = {q_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done = done_ff;
endmodule

[rtl/tcrr_datapath.sv]
// tcrr_datapath: tilt numerator, range and rate arithmetic, state registers.
// Depends on tcrr_pkg and tcrr_div.
module tcrr_datapath (
   input  logic clock,
   input  logic reset,
   input  tcrr_pkg::cmd_type cmd,
   output tcrr_pkg::stat_type stat,
   input  logic csr_write,
   input  logic [tcrr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [tcrr_pkg::CsrDataW-1:0] csr_data,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [23:0] req_down_pos_mm,
   input  logic [31:0] req_time_us,
   output logic signed [23:0] rsp_range_mm,
   output logic signed [15:0] rsp_rate_mm_s,
   output logic rsp_healthy
);
   import tcrr_pkg::*;

   logic signed [AxisW-1:0] ax_ff, ay_ff, az_ff;
   logic [BoundW-1:0] min_ff, max_ff;
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [23:0] down_ff;
   logic [31:0] now_ff;
   logic signed [RangeW-1:0] last_range_ff, range_ff;
   logic signed [RateW-1:0] last_rate_ff;
   logic was_ok_ff;
   logic [TimeW-1:0] last_time_ff;

   // numerator accumulation: one product per step
   logic signed [32:0] t_ff, t_in;   // 16x16 products and differences
   logic signed [50:0] acc_ff, acc_in;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] prod;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mstep)
         3'd0: begin mul_a = 34'(x_ff); mul_b = 17'(ay_ff); end
         3'd1: begin mul_a = 34'(y_ff); mul_b = 17'(ax_ff); end
         3'd2: begin mul_a = 34'(t_ff); mul_b = 17'(w_ff); end
         3'd3: begin mul_a = 34'(x_ff); mul_b = 17'(z_ff); end
         3'd4: begin mul_a = 34'(t_ff); mul_b = 17'(ax_ff); end
         3'd5: begin mul_a = 34'(y_ff); mul_b = 17'(z_ff); end
         3'd6: begin mul_a = 34'(t_ff); mul_b = 17'(ay_ff); end
         default: begin mul_a = 34'(t_ff); mul_b = 17'(az_ff); end
      endcase
      prod = 51'(mul_a) * 51'(mul_b);
   end

   // step sequence: t=x*ay; t-=y*ax; acc=w*t; t=x*z; acc+=t*ax; t=y*z; acc+=t*ay;
   // then x*x+y*y handled in step 7 via t prepared below
   logic [1:0] sq_ff;
   logic signed [32:0] sq_acc_ff;
   always_comb begin
      t_in = t_ff;
      acc_in = acc_ff;
      if (cmd.mvalid) begin
         case (cmd.mstep)
            3'd0: t_in = 33'(prod);
            3'd1: t_in = t_ff - 33'(prod);
            3'd2: acc_in = prod;
            3'd3: t_in = 33'(prod);
            3'd4: acc_in = acc_ff + prod;
            3'd5: t_in = 33'(prod);
            3'd6: begin acc_in = acc_ff + prod; t_in = sq_acc_ff; end
            default: acc_in = acc_ff - prod;
         endcase
      end
   end

   // x*x + y*y computed alongside, in the S_SQ state and multiply step 0
   logic signed [32:0] sq_prod;
   assign sq_prod = 33'(sq_ff[0] ? 32'(y_ff) * 32'(y_ff) : 32'(x_ff) * 32'(x_ff));

   // ratio = floor((az*2^28 + 2*acc) / 2^28) = az + floor(acc / 2^27)
   logic signed [24:0] ratio;
   assign ratio = 25'(az_ff) + 25'(acc_ff >>> 27);
   logic tilt_ok;
   assign tilt_ok = ratio > 25'(TiltLimit);

   // range division operands
   logic signed [24:0] neg_down;
   logic [40:0] rnum_mag;
   logic rneg;
   assign neg_down = -25'(down_ff);
   assign rneg = neg_down[24];
   assign rnum_mag = 41'(rneg ? -neg_down : neg_down) << 14;

   logic signed [25:0] delta;
   logic [45:0] dnum_mag;
   logic dneg;
   logic [31:0] dt;
   assign delta = 26'(range_ff) - 26'(last_range_ff);
   assign dneg = delta[25];
   // |delta| < 2^25, times 1e6 < 2^45
   assign dnum_mag = 46'(dneg ? -delta : delta) * 46'(UsPerS);
   assign dt = now_ff - last_time_ff;

   logic [DivW-1:0] div_n, div_d, div_q;
   logic div_done;
   assign div_n = cmd.div_sel ? DivW'(dnum_mag) : DivW'(rnum_mag);
   assign div_d = cmd.div_sel ? DivW'(dt) : DivW'(ratio);

   tcrr_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(div_n), .divisor(div_d), .quotient(div_q), .done(div_done)
   );

   logic signed [RangeW-1:0] range_sat;
   logic signed [DivW:0] rq;
   always_comb begin
      rq = rneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      if (rq > 51'sd8388607) range_sat = 24'sh7FFFFF;
      else if (rq < -51'sd8388608) range_sat = 24'sh800000;
      else range_sat = rq[RangeW-1:0];
   end

   logic range_ok;
   assign range_ok = (range_ff > $signed({1'b0, min_ff}))
                  && (range_ff < $signed({1'b0, max_ff}));

   logic need_rate;
   assign need_rate = range_ok && was_ok_ff && (dt != '0);

   logic signed [RateW:0] nr, fsum;
   always_comb begin
      if (div_q > DivW'(RateLimit)) nr = '0;
      else nr = dneg ? -17'(div_q[14:0]) : 17'(div_q[14:0]);
      fsum = 17'(last_rate_ff) + nr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff <= req_quat_w; x_ff <= req_quat_x;
         y_ff <= req_quat_y; z_ff <= req_quat_z;
         down_ff <= req_down_pos_mm; now_ff <= req_time_us;
         sq_ff <= 2'd0;
         sq_acc_ff <= '0;
      end else if (sq_ff != 2'd2) begin
         sq_acc_ff <= sq_acc_ff + sq_prod;
         sq_ff <= sq_ff + 2'd1;
      end
      t_ff <= t_in;
      acc_ff <= acc_in;
      if (cmd.range_take) range_ff <= range_sat;
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; az_ff <= 16'sd16384;
         min_ff <= 23'd200; max_ff <= 23'd8000;
         last_range_ff <= '0; last_rate_ff <= '0;
         was_ok_ff <= 1'b1; last_time_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_AXIS_X: ax_ff <= csr_data[AxisW-1:0];
               CSR_AXIS_Y: ay_ff <= csr_data[AxisW-1:0];
               CSR_AXIS_Z: az_ff <= csr_data[AxisW-1:0];
               CSR_MIN:    min_ff <= csr_data[BoundW-1:0];
               CSR_MAX:    max_ff <= csr_data[BoundW-1:0];
               default: ;
            endcase
         end
         if (cmd.finish) begin
            if (!tilt_ok) begin
               last_range_ff <= $signed({1'b0, max_ff});
               last_rate_ff <= '0;
               was_ok_ff <= 1'b0;
            end else begin
               last_range_ff <= range_ff;
               if (range_ok) begin
                  last_rate_ff <= need_rate ? fsum[RateW:1] : '0;
                  last_time_ff <= now_ff;
                  was_ok_ff <= 1'b1;
               end else begin
                  last_rate_ff <= '0;
                  was_ok_ff <= 1'b0;
               end
            end
         end
      end
   end

   assign stat.div_done = div_done;
   assign stat.tilt_ok = tilt_ok;
   assign stat.need_rate = need_rate;
   assign rsp_range_mm = last_range_ff;
   assign rsp_rate_mm_s = last_rate_ff;
   assign rsp_healthy = was_ok_ff;
endmodule

[rtl/tcrr_ctrl.sv]
// tcrr_ctrl: sequencer for one word: numerator, range divide, rate divide, update.
// Depends on tcrr_pkg.
module tcrr_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tcrr_pkg::cmd_type cmd,
   input  tcrr_pkg::stat_type stat
);
   import tcrr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SQ, S_MAC, S_RDIV, S_RWAIT, S_QDIV, S_QWAIT, S_DONE
   } state_type;

   state_type state_ff;
   logic [2:0] step_ff;
   logic out_ff;

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (out_ff && rsp_stall);
   assign rsp_valid = out_ff;

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      cmd.mstep = step_ff;
      cmd.mvalid = (state_ff == S_MAC);
      cmd.div_start = (state_ff == S_RDIV) || (state_ff == S_QDIV);
      cmd.div_sel = (state_ff == S_QDIV) || (state_ff == S_QWAIT) || (state_ff == S_DONE);
      cmd.range_take = (state_ff == S_RWAIT) && stat.div_done;
      cmd.finish = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         if (out_ff && !rsp_stall) out_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept) state_ff <= S_SQ;
            S_SQ: begin
               step_ff <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) state_ff <= S_RDIV;
            end
            S_RDIV: state_ff <= stat.tilt_ok ? S_RWAIT : S_DONE;
            S_RWAIT: if (stat.div_done) state_ff <= S_QDIV;
            S_QDIV: state_ff <= stat.need_rate ? S_QWAIT : S_DONE;
            S_QWAIT: if (stat.div_done) state_ff <= S_DONE;
            S_DONE: begin
               out_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/tilt_compensated_range_rate.sv]
// tilt_compensated_range_rate: top level, joins sequencer and datapath.
// Depends on tcrr_pkg, tcrr_ctrl, tcrr_datapath.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | quat w,x,y,z, down_pos_mm, time_us
//   rsp     | out       | rsp_valid/rsp_stall | range_mm, rate_mm_s, healthy
//   csr     | in        | csr_write          | csr_index, csr_data
//
// A word is taken in the idle cycle; its result follows an S_SQ state for x*x,
// 8 multiply steps, then one 50-step serial divider, used for the range when
// the tilt is good and again for the rate when a rate is needed.
// The next word can be taken in the cycle its result appears, unless rsp_stall
// holds that result.
// Reset is synchronous; state, CSR and result registers return to their reset
// values; the working registers of the datapath and divider are not reset.
// The result register holds while rsp_stall is high; a new word is taken once
// the sequencer is idle and no held result is stalled.
module tilt_compensated_range_rate (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [23:0] req_down_pos_mm,
   input  logic [31:0] req_time_us,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [23:0] rsp_range_mm,
   output logic signed [15:0] rsp_rate_mm_s,
   output logic rsp_healthy,
   input  logic csr_write,
   input  logic [tcrr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [tcrr_pkg::CsrDataW-1:0] csr_data
);
   import tcrr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tcrr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .stat(stat)
   );

   tcrr_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .req_down_pos_mm(req_down_pos_mm), .req_time_us(req_time_us),
      .rsp_range_mm(rsp_range_mm), .rsp_rate_mm_s(rsp_rate_mm_s),
      .rsp_healthy(rsp_healthy)
   );
endmodule
